[hdl/byte_ones_count_word_histogram_defines.svh]
// ----------------------------------------------------------------------------
// byte_ones_count_word_histogram_defines
// assertion macros shared by the checker of the ones-count word histogram
// ----------------------------------------------------------------------------
`ifndef BYTE_ONES_COUNT_WORD_HISTOGRAM_DEFINES_SVH
`define BYTE_ONES_COUNT_WORD_HISTOGRAM_DEFINES_SVH

// same-cycle implication under reset
`define BOCWH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bocwh assertion failed");

// next-cycle implication under reset
`define BOCWH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bocwh assertion failed");

`endif

[hdl/bocwh_pkg.sv]
// ----------------------------------------------------------------------------
// bocwh_pkg
// types and constants of the ones-count word histogram
// ----------------------------------------------------------------------------
package bocwh_pkg;

  localparam int unsigned FIVE_BINS   = 3125;
  localparam int unsigned FOUR_BINS   = 625;
  localparam int unsigned BIN_COUNT_W = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic TABLE_FIVE = 1'b0;
  localparam logic TABLE_FOUR = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_COUNT,
    OP_READ,
    OP_CLEAR
  } back_op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        bin_table;
    logic [11:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic        word_counted;
    logic [11:0] word_five;
    logic [9:0]  word_four;
    logic [31:0] bin_count;
    logic        bad_index;
  } out_item_t;

  typedef struct packed {
    back_op_e    op;
    logic        rd_table;
    logic        bad;
    logic [11:0] word_five;
    logic [9:0]  word_four;
    logic [11:0] addr_five;
    logic [9:0]  addr_four;
  } work_t;

endpackage

[hdl/bocwh_front.sv]
// ----------------------------------------------------------------------------
// bocwh_front
// accepts commands, maps bytes to letters, keeps history and phase
// ----------------------------------------------------------------------------
module bocwh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bocwh_pkg::in_item_t in_item_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               sweep_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output bocwh_pkg::work_t   q_item_o
);

  logic        overlap_q, overlap_d;
  logic [11:0] hist_q, hist_d;
  logic [2:0]  phase_q, phase_d;
  logic        accept;
  logic        is_feed, is_read, is_clear, take, bad;
  logic [3:0]  ones;
  logic [2:0]  letter;
  logic [13:0] raw;
  logic [13:0] next_wide;
  logic [11:0] next_hist;
  logic [11:0] shown;
  logic [11:0] four_wide;

  assign in_stall_o = q_full_i | sweep_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_feed    = in_item_i.cmd == bocwh_pkg::CMD_FEED;
  assign is_read    = in_item_i.cmd == bocwh_pkg::CMD_READ;
  assign is_clear   = in_item_i.cmd == bocwh_pkg::CMD_CLEAR;
  assign take       = phase_q >= 3'd4;

  always_comb begin
    ones = 4'($countones(in_item_i.data_byte));
    case (ones) inside
      [4'd0:4'd2]: letter = 3'd0;
      4'd3:        letter = 3'd1;
      4'd4:        letter = 3'd2;
      4'd5:        letter = 3'd3;
      default:     letter = 3'd4;
    endcase
  end

  // history * 5 + letter, then drop the oldest base-5 digit
  always_comb begin
    raw = {hist_q, 2'b00} + 14'(hist_q) + 14'(letter);
    if (raw >= 14'(4 * bocwh_pkg::FIVE_BINS)) begin
      next_wide = raw - 14'(4 * bocwh_pkg::FIVE_BINS);
    end else if (raw >= 14'(3 * bocwh_pkg::FIVE_BINS)) begin
      next_wide = raw - 14'(3 * bocwh_pkg::FIVE_BINS);
    end else if (raw >= 14'(2 * bocwh_pkg::FIVE_BINS)) begin
      next_wide = raw - 14'(2 * bocwh_pkg::FIVE_BINS);
    end else if (raw >= 14'(bocwh_pkg::FIVE_BINS)) begin
      next_wide = raw - 14'(bocwh_pkg::FIVE_BINS);
    end else begin
      next_wide = raw;
    end
    next_hist = next_wide[11:0];
  end

  always_comb begin
    hist_d  = hist_q;
    phase_d = phase_q;
    if (is_feed) begin
      hist_d = next_hist;
      if (overlap_q) begin
        if (!take) begin
          phase_d = phase_q + 3'd1;
        end
      end else begin
        phase_d = take ? 3'd0 : phase_q + 3'd1;
      end
    end else if (is_clear) begin
      hist_d  = '0;
      phase_d = '0;
    end
  end

  assign overlap_d = cfg_we_i ? cfg_wdata_i : overlap_q;

  always_comb begin
    shown = hist_d;
    if (shown >= 12'(4 * bocwh_pkg::FOUR_BINS)) begin
      four_wide = shown - 12'(4 * bocwh_pkg::FOUR_BINS);
    end else if (shown >= 12'(3 * bocwh_pkg::FOUR_BINS)) begin
      four_wide = shown - 12'(3 * bocwh_pkg::FOUR_BINS);
    end else if (shown >= 12'(2 * bocwh_pkg::FOUR_BINS)) begin
      four_wide = shown - 12'(2 * bocwh_pkg::FOUR_BINS);
    end else if (shown >= 12'(bocwh_pkg::FOUR_BINS)) begin
      four_wide = shown - 12'(bocwh_pkg::FOUR_BINS);
    end else begin
      four_wide = shown;
    end
  end

  always_comb begin
    if (in_item_i.bin_table == bocwh_pkg::TABLE_FIVE) begin
      bad = in_item_i.bin_index >= 12'(bocwh_pkg::FIVE_BINS);
    end else begin
      bad = in_item_i.bin_index >= 12'(bocwh_pkg::FOUR_BINS);
    end
  end

  always_comb begin
    q_item_o           = '0;
    q_item_o.op        = bocwh_pkg::OP_NONE;
    q_item_o.rd_table  = in_item_i.bin_table;
    q_item_o.word_five = shown;
    q_item_o.word_four = four_wide[9:0];
    if (is_feed && take) begin
      q_item_o.op        = bocwh_pkg::OP_COUNT;
      q_item_o.addr_five = shown;
      q_item_o.addr_four = four_wide[9:0];
    end else if (is_read) begin
      q_item_o.bad = bad;
      if (!bad) begin
        q_item_o.op = bocwh_pkg::OP_READ;
        if (in_item_i.bin_table == bocwh_pkg::TABLE_FIVE) begin
          q_item_o.addr_five = in_item_i.bin_index;
        end else begin
          q_item_o.addr_four = in_item_i.bin_index[9:0];
        end
      end
    end else if (is_clear) begin
      q_item_o.op = bocwh_pkg::OP_CLEAR;
    end
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_q <= 1'b1;
      hist_q    <= '0;
      phase_q   <= '0;
    end else begin
      overlap_q <= overlap_d;
      if (accept) begin
        hist_q  <= hist_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

[hdl/bocwh_queue.sv]
// ----------------------------------------------------------------------------
// bocwh_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module bocwh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bocwh_pkg::work_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output bocwh_pkg::work_t head_item_o
);

  bocwh_pkg::work_t                        entry_q [bocwh_pkg::QUEUE_DEPTH];
  logic [bocwh_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [bocwh_pkg::QUEUE_CNT_W-1:0]       cnt_q;

  assign full_o       = cnt_q == bocwh_pkg::QUEUE_CNT_W'(bocwh_pkg::QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/bocwh_back.sv]
// ----------------------------------------------------------------------------
// bocwh_back
// histogram memories, read-modify-write, clearing sweep and result register
// ----------------------------------------------------------------------------
module bocwh_back #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  bocwh_pkg::work_t     head_item_i,
  output logic                 pop_o,
  output logic                 sweep_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bocwh_pkg::out_item_t out_item_o
);

  logic [CountWidth-1:0] five_mem [bocwh_pkg::FIVE_BINS];
  logic [CountWidth-1:0] four_mem [bocwh_pkg::FOUR_BINS];

  logic [CountWidth-1:0] rd5_q, rd4_q;
  bocwh_pkg::work_t      b_q;
  logic                  b_valid_q;
  logic                  sweep_q;
  logic [11:0]           sweep_addr_q;
  logic                  byp5_v_q, byp4_v_q;
  logic [11:0]           byp5_a_q;
  logic [9:0]            byp4_a_q;
  logic [CountWidth-1:0] byp5_d_q, byp4_d_q;
  logic                  out_valid_q;
  bocwh_pkg::out_item_t  out_q, res;
  logic                  b_go, commit_count;
  logic [CountWidth-1:0] cur5, cur4, inc5, inc4, sel;
  logic [31:0]           sel32;

  assign b_go         = b_valid_q & (~out_valid_q | ~out_stall_i);
  assign commit_count = b_go & (b_q.op == bocwh_pkg::OP_COUNT);
  assign pop_o        = head_valid_i & ~sweep_q &
                        (~b_valid_q | (b_go & (b_q.op != bocwh_pkg::OP_CLEAR)));
  assign sweep_o      = sweep_q;

  assign cur5 = (byp5_v_q && byp5_a_q == b_q.addr_five) ? byp5_d_q : rd5_q;
  assign cur4 = (byp4_v_q && byp4_a_q == b_q.addr_four) ? byp4_d_q : rd4_q;
  assign inc5 = (&cur5) ? cur5 : cur5 + 1'b1;
  assign inc4 = (&cur4) ? cur4 : cur4 + 1'b1;
  assign sel  = (b_q.rd_table == bocwh_pkg::TABLE_FIVE) ? cur5 : cur4;

  generate
    if (CountWidth > bocwh_pkg::BIN_COUNT_W) begin : g_sat
      assign sel32 = (|sel[CountWidth-1:bocwh_pkg::BIN_COUNT_W]) ? '1 : sel[31:0];
    end else begin : g_ext
      assign sel32 = 32'(sel);
    end
  endgenerate

  always_comb begin
    res              = '0;
    res.word_counted = b_q.op == bocwh_pkg::OP_COUNT;
    res.word_five    = b_q.word_five;
    res.word_four    = b_q.word_four;
    res.bad_index    = b_q.bad;
    if (b_q.op == bocwh_pkg::OP_READ) begin
      res.bin_count = sel32;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      five_mem[sweep_addr_q] <= '0;
      if (sweep_addr_q < 12'(bocwh_pkg::FOUR_BINS)) begin
        four_mem[sweep_addr_q[9:0]] <= '0;
      end
    end else if (commit_count) begin
      five_mem[b_q.addr_five] <= inc5;
      four_mem[b_q.addr_four] <= inc4;
    end
    if (pop_o) begin
      rd5_q <= five_mem[head_item_i.addr_five];
      rd4_q <= four_mem[head_item_i.addr_four];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q <= head_item_i;
    end
    if (commit_count) begin
      byp5_a_q <= b_q.addr_five;
      byp5_d_q <= inc5;
      byp4_a_q <= b_q.addr_four;
      byp4_d_q <= inc4;
    end
    if (b_go) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q    <= 1'b0;
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      byp5_v_q     <= 1'b0;
      byp4_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
      if (sweep_q) begin
        byp5_v_q     <= 1'b0;
        byp4_v_q     <= 1'b0;
        sweep_addr_q <= sweep_addr_q + 1'b1;
        if (sweep_addr_q == 12'(bocwh_pkg::FIVE_BINS - 1)) begin
          sweep_q <= 1'b0;
        end
      end else if (b_go && b_q.op == bocwh_pkg::OP_CLEAR) begin
        sweep_q      <= 1'b1;
        sweep_addr_q <= '0;
      end else if (commit_count) begin
        byp5_v_q <= 1'b1;
        byp4_v_q <= 1'b1;
      end
      if (b_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hdl/byte_ones_count_word_histogram.sv]
// ----------------------------------------------------------------------------
// byte_ones_count_word_histogram
// ones-count letters of a byte stream counted into five- and four-letter bins
//
//   channel  direction  handshake                 beat
//   in       input      in_valid_i / in_stall_o   in_item_i  (feed, read, clear)
//   out      output     out_valid_o / out_stall_i out_item_o (one per input)
//   cfg      input      cfg_we_i                  cfg_wdata_i (overlap mode)
//
// one beat per cycle sustained while no output stall, clear or sweep holds the
// flow; an accepted input beat passes the queue entry, the back-end work
// register and the output register before its result beat is offered
// after reset the memories are swept to zero over all 3125 bins with in_stall_o high
// a clear command starts the same sweep in the back end
// the four-entry queue lets the front take beats while the output is stalled
// ----------------------------------------------------------------------------
module byte_ones_count_word_histogram #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bocwh_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bocwh_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);

  logic             q_full, q_push, q_pop, head_valid, sweep;
  bocwh_pkg::work_t q_item, head_item;

  bocwh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sweep_i     (sweep),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_item)
  );

  bocwh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (q_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  bocwh_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (q_pop),
    .sweep_o      (sweep),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

[hdl/bocwh_checker.sv]
// ----------------------------------------------------------------------------
// bocwh_checker
// port-level checks of the ones-count word histogram, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_ones_count_word_histogram_defines.svh"

module bocwh_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input bocwh_pkg::out_item_t out_item_o
);

  `BOCWH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `BOCWH_ASSERT_SAME(a_word_range, clk_i, rst_ni, out_valid_o, (out_item_o.word_five < 12'd3125) && (out_item_o.word_four < 10'd625))
  `BOCWH_ASSERT_SAME(a_bad_zero, clk_i, rst_ni, out_valid_o && out_item_o.bad_index, (out_item_o.bin_count == '0) && !out_item_o.word_counted)
  `BOCWH_ASSERT_SAME(a_count_no_read, clk_i, rst_ni, out_valid_o && out_item_o.word_counted, out_item_o.bin_count == '0)

endmodule

bind byte_ones_count_word_histogram bocwh_checker u_bocwh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
